FILE: rtl/wmpe_pkg.sv
// Shared widths, register indexes, reset values and types for the waveform envelope block.
`default_nettype none
package wmpe_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ROW_W    = 12;
  localparam int AMP_W    = 15;
  localparam int COUNT_W  = 16;
  localparam int MAG_W    = 17;   // |sample| reaches 32768
  localparam int PROD_W   = 32;
  localparam int SCALE_SH = 15;   // divide by 0x8000
  localparam int Q_W      = 15;   // |sample| * amp / 0x8000 stays below 2^15
  localparam int ROW_S_W  = 18;   // signed row before the clamp
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEIGHT     = 4'd0,
    REG_AMPLITUDE  = 4'd1,
    REG_SAMPLES    = 4'd2,
    REG_COLUMNS    = 4'd3
  } cfg_reg_t;

  localparam logic [ROW_W-1:0]   RESET_HEIGHT    = 12'd256;
  localparam logic [AMP_W-1:0]   RESET_AMPLITUDE = 15'd128;
  localparam logic [COUNT_W-1:0] RESET_SAMPLES   = 16'd1;
  localparam logic [COUNT_W-1:0] RESET_COLUMNS   = 16'd1;

  // scaled sample handed from the multiply stage to the reduce stage
  typedef struct packed {
    logic           valid;
    logic           neg;
    logic [Q_W-1:0] q;
  } scaled_t;

endpackage
`default_nettype wire

FILE: rtl/wmpe_if.sv
// Channel interfaces: sample requests, column results and register writes.
`default_nettype none
interface wmpe_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wmpe_column_if;
  logic        valid;
  logic        ready;
  logic [11:0] min_row;
  logic [11:0] peak_row;
  logic        last_column;
  modport source (output valid, output min_row, output peak_row, output last_column,
                  input ready);
  modport sink   (input valid, input min_row, input peak_row, input last_column,
                  output ready);
endinterface

interface wmpe_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/wmpe_scale.sv
// Input register and scaling multiply stage: |sample| * amplitude / 0x8000.
`default_nettype none
module wmpe_scale (
  input  logic                          clk,
  input  logic                          rst,
  wmpe_sample_if.sink                   samples,
  input  logic [wmpe_pkg::AMP_W-1:0]    amplitude,
  input  logic                          take,      // reduce stage consumes scaled this cycle
  output wmpe_pkg::scaled_t             scaled
);
  import wmpe_pkg::*;

  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s2_ready;
  logic                s1_move;
  logic [MAG_W-1:0]    mag;
  logic [PROD_W-1:0]   prod;

  assign s2_ready      = !scaled.valid || take;
  assign s1_move       = s1_valid && s2_ready;
  assign samples.ready = !s1_valid || s2_ready;

  // magnitude of a two's complement sample, -32768 gives 32768
  assign mag  = s1_sample[SAMPLE_W-1] ? (MAG_W'(17'h10000) - {1'b0, s1_sample})
                                      : {1'b0, s1_sample};
  assign prod = PROD_W'(mag) * PROD_W'(amplitude);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.valid && samples.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (samples.valid && samples.ready) begin
      s1_sample <= samples.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scaled.valid <= 1'b0;
    end else if (s2_ready) begin
      scaled.valid <= s1_valid;
    end
    if (s1_move) begin
      scaled.neg <= s1_sample[SAMPLE_W-1];
      scaled.q   <= prod[SCALE_SH +: Q_W];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/waveform_min_peak_envelope.sv
// Top level of the min/peak waveform envelope reducer.
// Takes one signed 16-bit sample per request, maps it to a display row
// floor(height/2) - sample*amplitude/0x8000 (truncated toward zero), clamps the
// row to 0..height, and after every samples_per_column samples returns one
// column request carrying the lowest and highest row of that group.
// The column_count-th column of a run is flagged last_column and the counter
// restarts. A zero in samples_per_column or column_count counts as 65536.
// Rate: one sample per clock sustained. A sample goes through three register
// levels (input register, multiply register, result register) before its
// column is presented. The single 17x15 multiply and the row clamp/compare
// stage set this pace; the result register lets the next samples flow while a
// column waits to be taken, and only a second column behind a stalled one
// holds the pipe.
// Registers are written over cfg (index 0 height, 1 amplitude,
// 2 samples_per_column, 3 column_count; other indexes are dropped) and must
// only be written while no sample is in flight.
`default_nettype none
module waveform_min_peak_envelope (
  input  logic          clk,
  input  logic          rst,
  wmpe_sample_if.sink   samples,
  wmpe_column_if.source columns,
  wmpe_cfg_if.sink      cfg
);
  import wmpe_pkg::*;

  // configuration registers
  logic [ROW_W-1:0]   height;
  logic [AMP_W-1:0]   amplitude;
  logic [COUNT_W-1:0] samples_per_column;
  logic [COUNT_W-1:0] column_count;

  // reduction state
  logic [COUNT_W-1:0] sample_in_column;
  logic [COUNT_W-1:0] column_index;
  logic [ROW_W-1:0]   running_min;
  logic [ROW_W-1:0]   running_peak;

  // result register
  logic               out_valid;
  logic [ROW_W-1:0]   out_min;
  logic [ROW_W-1:0]   out_peak;
  logic               out_last;

  scaled_t            scaled;
  logic               upd_take;
  logic               upd_emit;
  logic               upd_last;
  logic [COUNT_W-1:0] sample_next;
  logic [COUNT_W-1:0] column_next;
  logic signed [ROW_S_W-1:0] half_s;
  logic signed [ROW_S_W-1:0] q_s;
  logic signed [ROW_S_W-1:0] row_s;
  logic [ROW_W-1:0]   row;
  logic [ROW_W-1:0]   min_next;
  logic [ROW_W-1:0]   peak_next;

  // ---------------------------------------------------------------------------
  // Register writes; the port never pushes back.
  // ---------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      height             <= RESET_HEIGHT;
      amplitude          <= RESET_AMPLITUDE;
      samples_per_column <= RESET_SAMPLES;
      column_count       <= RESET_COLUMNS;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_HEIGHT:    height             <= cfg.data[ROW_W-1:0];
        REG_AMPLITUDE: amplitude          <= cfg.data[AMP_W-1:0];
        REG_SAMPLES:   samples_per_column <= cfg.data[COUNT_W-1:0];
        REG_COLUMNS:   column_count       <= cfg.data[COUNT_W-1:0];
        default: ;     // unknown index, dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input and multiply stages.
  // ---------------------------------------------------------------------------
  wmpe_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .amplitude (amplitude),
    .take      (upd_take),
    .scaled    (scaled)
  );

  // ---------------------------------------------------------------------------
  // Reduce stage: row mapping, clamp, running min/peak and column counters.
  // ---------------------------------------------------------------------------
  assign half_s = ROW_S_W'({1'b0, height[ROW_W-1:1]});
  assign q_s    = ROW_S_W'(scaled.q);
  // negative sample raises the row
  assign row_s  = scaled.neg ? (half_s + q_s) : (half_s - q_s);

  always_comb begin
    if (row_s < 0) begin
      row = '0;
    end else if (row_s > ROW_S_W'(height)) begin
      row = height;
    end else begin
      row = row_s[ROW_W-1:0];
    end
  end

  assign min_next  = (row < running_min)  ? row : running_min;
  assign peak_next = (row > running_peak) ? row : running_peak;

  // counters wrap at 16 bits, so a zero limit means 65536
  assign sample_next = sample_in_column + COUNT_W'(1);
  assign column_next = column_index + COUNT_W'(1);
  assign upd_emit    = (sample_next == samples_per_column);
  assign upd_last    = (column_next == column_count);

  // a closing sample waits only while the result register is full and columns.ready is low
  assign upd_take = scaled.valid && (!upd_emit || !out_valid || columns.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_in_column <= '0;
      column_index     <= '0;
      running_min      <= RESET_HEIGHT;
      running_peak     <= '0;
    end else if (upd_take) begin
      if (upd_emit) begin
        sample_in_column <= '0;
        column_index     <= upd_last ? '0 : column_next;
        running_min      <= height;
        running_peak     <= '0;
      end else begin
        sample_in_column <= sample_next;
        running_min      <= min_next;
        running_peak     <= peak_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_take && upd_emit) begin
      out_valid <= 1'b1;
    end else if (columns.ready) begin
      out_valid <= 1'b0;
    end
    if (upd_take && upd_emit) begin
      out_min  <= min_next;
      out_peak <= peak_next;
      out_last <= upd_last;
    end
  end

  assign columns.valid       = out_valid;
  assign columns.min_row     = out_min;
  assign columns.peak_row    = out_peak;
  assign columns.last_column = out_last;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !columns.ready) |-> !(upd_take && upd_emit))
    else $error("column result overwritten while stalled");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (upd_take && upd_emit) |=> (out_valid && sample_in_column == '0 && running_peak == '0))
    else $error("column close did not load result and restart column");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (upd_take && upd_emit && upd_last) |=> (column_index == '0 && out_last))
    else $error("last column did not restart run");

  a_mid_column_no_result: assert property (@(posedge clk) disable iff (rst)
    (upd_take && !upd_emit && !columns.ready && out_valid) |=>
      (out_valid && $stable(out_min) && $stable(out_peak)))
    else $error("result changed without a column close");

endmodule
`default_nettype wire
